// ===== hdl/pfb_pkg.sv =====
// Shared types and constants of the precedence function builder.
`default_nettype none
package pfb_pkg;

	localparam int CFG_W   = 6;
	localparam int SYM_W   = 5;
	localparam int REL_W   = 2;
	localparam int VALUE_W = 7;
	localparam int GRP_W   = 4;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [REL_W-1:0] REL_NONE    = 2'd0;
	localparam logic [REL_W-1:0] REL_GREATER = 2'd1;
	localparam logic [REL_W-1:0] REL_LESS    = 2'd2;
	localparam logic [REL_W-1:0] REL_EQUAL   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PIV_RD,
		ST_PIV_LD,
		ST_SWEEP,
		ST_EMIT_RD,
		ST_EMIT_GRP,
		ST_EMIT_SUM,
		ST_EMIT_F,
		ST_EMIT_G,
		ST_CLEAR
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/precedence_function_builder_unit.sv =====
// Precedence function builder: Bell's method over a reachability matrix in two row memories.
//
// Input channel (in_valid/in_ready) carries op, row_symbol, col_symbol, relation.
// A load (op 0) sets up to two matrix bits and leaves in_ready high, so loads transfer
// back to back, one per cycle, with no result. A compute (op 1) takes n, the
// symbol count saturated to MAX_SYMBOLS, and runs Warshall's closure: 2n pivots,
// each a pivot row read and a read-modify-write sweep of n rows in the f and g
// memories side by side. Emission then reads one f row and one g row per symbol,
// counts ones in two registered steps and delivers f then g on the output
// channel (out_valid/out_ready); last marks the final g. A clearing pass then
// zeroes every row of both memories. in_ready is low from the compute transfer
// to the end of that pass. A stalled receiver holds the output register and
// the emission sequencer waits on it.
// The cfg_we/cfg_wdata port writes symbol_count at once; write it only while idle.
// After arst_n the matrix is cleared by the same pass before the first input
// transfer; symbol_count resets to 1.
`default_nettype none
module precedence_function_builder_unit #(
	parameter int MAX_SYMBOLS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [pfb_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          op,
	input  wire  [pfb_pkg::SYM_W-1:0]    row_symbol,
	input  wire  [pfb_pkg::SYM_W-1:0]    col_symbol,
	input  wire  [pfb_pkg::REL_W-1:0]    relation,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         is_g,
	output logic [pfb_pkg::SYM_W-1:0]    symbol_index,
	output logic [pfb_pkg::VALUE_W-1:0]  func_value,
	output logic                         last
);

	localparam int NODES  = 2 * MAX_SYMBOLS;
	localparam int ROW_W  = $clog2(MAX_SYMBOLS);
	localparam int NODE_W = ROW_W + 1;
	localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
	localparam int GROUPS = (NODES + 7) / 8;
	localparam int PAD_W  = GROUPS * 8;

	pfb_pkg::state_t state_q, state_d;

	logic [NODES-1:0] f_mem [MAX_SYMBOLS];
	logic [NODES-1:0] g_mem [MAX_SYMBOLS];
	logic [NODES-1:0] f_rd_q, g_rd_q;

	logic [pfb_pkg::CFG_W-1:0] count_q;
	logic [CNT_W-1:0]          n_q, n_sat;
	logic [NODES-1:0]          used_q, used_d;
	logic                      side_q;
	logic [ROW_W-1:0]          k_q, wr_q, s_q, clr_q;
	logic [NODES-1:0]          pivot_q;
	logic [pfb_pkg::GRP_W-1:0] grp_f_q [GROUPS];
	logic [pfb_pkg::GRP_W-1:0] grp_g_q [GROUPS];
	logic [pfb_pkg::GRP_W-1:0] grp_f_d [GROUPS];
	logic [pfb_pkg::GRP_W-1:0] grp_g_d [GROUPS];
	logic [pfb_pkg::VALUE_W-1:0] cnt_f_q, cnt_g_q, sum_f, sum_g;

	logic                       out_valid_q, is_g_q, last_q;
	logic [pfb_pkg::SYM_W-1:0]  symbol_index_q;
	logic [pfb_pkg::VALUE_W-1:0] func_value_q;

	logic             in_xfer, out_free, load_ok, sym_last;
	logic             rd_en, row_we, f_bit_we, g_bit_we;
	logic [ROW_W-1:0] rd_addr, wr_addr, ld_row, ld_col;
	logic [NODES-1:0] f_wdata, g_wdata;
	logic [NODE_W-1:0] knode, node_f, node_g, f_bit_idx;
	logic [NODES-1:0] pivot_clean, f_clean, g_clean;
	logic [PAD_W-1:0] f_pad, g_pad;
	logic             piv_last, sweep_last, sweep_more;

	assign in_ready     = (state_q == pfb_pkg::ST_IDLE);
	assign in_xfer      = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign is_g         = is_g_q;
	assign symbol_index = symbol_index_q;
	assign func_value   = func_value_q;
	assign last         = last_q;

	assign n_sat = (count_q > pfb_pkg::CFG_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS)
		: CNT_W'(count_q);

	always_comb begin
		for (int b = 0; b < MAX_SYMBOLS; b++) begin
			used_d[b]               = (CNT_W'(b) < n_sat);
			used_d[MAX_SYMBOLS + b] = (CNT_W'(b) < n_sat);
		end
	end

	assign load_ok = ({1'b0, row_symbol} < (pfb_pkg::SYM_W + 1)'(MAX_SYMBOLS))
		&& ({1'b0, col_symbol} < (pfb_pkg::SYM_W + 1)'(MAX_SYMBOLS));
	assign ld_row    = row_symbol[ROW_W-1:0];
	assign ld_col    = col_symbol[ROW_W-1:0];
	assign f_bit_idx = NODE_W'(MAX_SYMBOLS) + NODE_W'(ld_col);

	assign knode  = side_q ? (NODE_W'(MAX_SYMBOLS) + NODE_W'(k_q)) : NODE_W'(k_q);
	assign node_f = NODE_W'(wr_q);
	assign node_g = NODE_W'(MAX_SYMBOLS) + NODE_W'(wr_q);

	assign pivot_clean = ((side_q ? g_rd_q : f_rd_q) & used_q) | (NODES'(1) << knode);
	assign f_clean     = (f_rd_q & used_q) | (NODES'(1) << node_f);
	assign g_clean     = (g_rd_q & used_q) | (NODES'(1) << node_g);

	assign piv_last   = (CNT_W'(k_q) + CNT_W'(1) == n_q);
	assign sweep_last = (CNT_W'(wr_q) + CNT_W'(1) == n_q);
	assign sweep_more = (CNT_W'(wr_q) + CNT_W'(1) < n_q);
	assign sym_last   = (CNT_W'(s_q) + CNT_W'(1) == n_q);

	assign f_pad = PAD_W'(f_rd_q);
	assign g_pad = PAD_W'(g_rd_q);

	always_comb begin
		for (int gi = 0; gi < GROUPS; gi++) begin
			grp_f_d[gi] = '0;
			grp_g_d[gi] = '0;
			for (int b = 0; b < 8; b++) begin
				grp_f_d[gi] = grp_f_d[gi] + pfb_pkg::GRP_W'(f_pad[gi * 8 + b]);
				grp_g_d[gi] = grp_g_d[gi] + pfb_pkg::GRP_W'(g_pad[gi * 8 + b]);
			end
		end
	end

	always_comb begin
		sum_f = '0;
		sum_g = '0;
		for (int gi = 0; gi < GROUPS; gi++) begin
			sum_f = sum_f + pfb_pkg::VALUE_W'(grp_f_q[gi]);
			sum_g = sum_g + pfb_pkg::VALUE_W'(grp_g_q[gi]);
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = k_q;
		row_we   = 1'b0;
		wr_addr  = wr_q;
		f_wdata  = f_clean | (f_clean[knode] ? pivot_q : '0);
		g_wdata  = g_clean | (g_clean[knode] ? pivot_q : '0);
		f_bit_we = 1'b0;
		g_bit_we = 1'b0;
		case (state_q)
			pfb_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (op == pfb_pkg::OP_COMPUTE) begin
						state_d = (n_sat == '0) ? pfb_pkg::ST_CLEAR : pfb_pkg::ST_PIV_RD;
					end else if (load_ok) begin
						f_bit_we = relation inside {pfb_pkg::REL_GREATER, pfb_pkg::REL_EQUAL};
						g_bit_we = relation inside {pfb_pkg::REL_LESS, pfb_pkg::REL_EQUAL};
					end
				end
			end
			pfb_pkg::ST_PIV_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
				state_d = pfb_pkg::ST_PIV_LD;
			end
			pfb_pkg::ST_PIV_LD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = pfb_pkg::ST_SWEEP;
			end
			pfb_pkg::ST_SWEEP: begin
				row_we  = 1'b1;
				wr_addr = wr_q;
				rd_en   = sweep_more;
				rd_addr = ROW_W'(CNT_W'(wr_q) + CNT_W'(1));
				if (sweep_last) begin
					if (piv_last && side_q) begin
						state_d = pfb_pkg::ST_EMIT_RD;
					end else begin
						state_d = pfb_pkg::ST_PIV_RD;
					end
				end
			end
			pfb_pkg::ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = s_q;
				state_d = pfb_pkg::ST_EMIT_GRP;
			end
			pfb_pkg::ST_EMIT_GRP: begin
				state_d = pfb_pkg::ST_EMIT_SUM;
			end
			pfb_pkg::ST_EMIT_SUM: begin
				state_d = pfb_pkg::ST_EMIT_F;
			end
			pfb_pkg::ST_EMIT_F: begin
				if (out_free) begin
					state_d = pfb_pkg::ST_EMIT_G;
				end
			end
			pfb_pkg::ST_EMIT_G: begin
				if (out_free) begin
					state_d = sym_last ? pfb_pkg::ST_CLEAR : pfb_pkg::ST_EMIT_RD;
				end
			end
			pfb_pkg::ST_CLEAR: begin
				row_we  = 1'b1;
				wr_addr = clr_q;
				f_wdata = '0;
				g_wdata = '0;
				if (clr_q == ROW_W'(MAX_SYMBOLS - 1)) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfb_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			f_rd_q <= f_mem[rd_addr];
			g_rd_q <= g_mem[rd_addr];
		end
		if (row_we) begin
			f_mem[wr_addr] <= f_wdata;
			g_mem[wr_addr] <= g_wdata;
		end
		if (f_bit_we) begin
			f_mem[ld_row][f_bit_idx] <= 1'b1;
		end
		if (g_bit_we) begin
			g_mem[ld_col][NODE_W'(ld_row)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfb_pkg::ST_CLEAR;
			count_q     <= pfb_pkg::CFG_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (state_q == pfb_pkg::ST_CLEAR) begin
				clr_q <= (clr_q == ROW_W'(MAX_SYMBOLS - 1)) ? '0 : clr_q + ROW_W'(1);
			end
			if ((state_q == pfb_pkg::ST_EMIT_F || state_q == pfb_pkg::ST_EMIT_G)
				&& out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pfb_pkg::ST_IDLE: begin
				n_q    <= n_sat;
				used_q <= used_d;
				side_q <= 1'b0;
				k_q    <= '0;
				s_q    <= '0;
			end
			pfb_pkg::ST_PIV_LD: begin
				pivot_q <= pivot_clean;
				wr_q    <= '0;
			end
			pfb_pkg::ST_SWEEP: begin
				wr_q <= wr_q + ROW_W'(1);
				if (sweep_last) begin
					if (piv_last) begin
						side_q <= 1'b1;
						k_q    <= '0;
					end else begin
						k_q <= k_q + ROW_W'(1);
					end
				end
			end
			pfb_pkg::ST_EMIT_GRP: begin
				grp_f_q <= grp_f_d;
				grp_g_q <= grp_g_d;
			end
			pfb_pkg::ST_EMIT_SUM: begin
				cnt_f_q <= sum_f;
				cnt_g_q <= sum_g;
			end
			pfb_pkg::ST_EMIT_F: begin
				if (out_free) begin
					is_g_q         <= 1'b0;
					symbol_index_q <= pfb_pkg::SYM_W'(s_q);
					func_value_q   <= cnt_f_q;
					last_q         <= 1'b0;
				end
			end
			pfb_pkg::ST_EMIT_G: begin
				if (out_free) begin
					is_g_q         <= 1'b1;
					symbol_index_q <= pfb_pkg::SYM_W'(s_q);
					func_value_q   <= cnt_g_q;
					last_q         <= sym_last;
					s_q            <= s_q + ROW_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
